// File: hdl/sprp_pkg.sv
// ----------------------------------------------------------------------------
// sprp_pkg: shared types for the strong probable prime test
// Controller states, multiplier operand selects, command and status bundles.
// ----------------------------------------------------------------------------
package sprp_pkg;

  localparam int NUM_BITS_DEF = 32;
  localparam int IN_WIDTH     = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,
    S_EXP,
    S_CHK0,
    S_CHK,
    S_RED,
    S_DONE_T,
    S_DONE_F,
    S_DONE_BAD
  } state_t;

  typedef enum logic [1:0] {
    MS_ACC_SQ,
    MS_SQ_SQ,
    MS_ACC_ACC
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     strip;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     red_step;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic d_lsb;
    logic d_zero;
    logic acc_is1;
    logic acc_is_nm1;
    logic r_eq_s;
    logic red_last;
  } sts_t;

endpackage

// File: hdl/strong_probable_prime_test.sv
// Each test runs M modular multiplies (M <= 2*NUM_BITS-1); a candidate below two
// goes straight to the bad-input result without any multiply.
// One test at a time: in_ready is high only in the idle state.
// Each modular multiply is set by the bit-serial remainder loop over the product.
// Reset: rst_n synchronous active low, returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
// strong_probable_prime_test: one Miller-Rabin round on a 32-bit candidate
// Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module strong_probable_prime_test #(
  parameter int NUM_BITS = sprp_pkg::NUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sprp_pkg::IN_WIDTH-1:0] in_candidate,
  input  logic [sprp_pkg::IN_WIDTH-1:0] in_base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_probable_prime,
  output logic                          out_bad_input
);
  import sprp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sprp_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_probable_prime (out_probable_prime),
    .out_bad_input      (out_bad_input),
    .sts                (sts),
    .cmd                (cmd)
  );

  sprp_datapath #(.NUM_BITS(NUM_BITS)) u_dp (
    .clk          (clk),
    .in_candidate (in_candidate),
    .in_base      (in_base),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// File: hdl/sprp_datapath.sv
// ----------------------------------------------------------------------------
// sprp_datapath: operand registers and modular multiplier
// Registered product, then a bit-serial restoring remainder over its 2*W bits.
// ----------------------------------------------------------------------------
module sprp_datapath #(
  parameter int NUM_BITS = sprp_pkg::NUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic [sprp_pkg::IN_WIDTH-1:0] in_candidate,
  input  logic [sprp_pkg::IN_WIDTH-1:0] in_base,
  input  sprp_pkg::cmd_t                cmd,
  output sprp_pkg::sts_t                sts
);
  import sprp_pkg::*;

  localparam int W  = NUM_BITS;
  localparam int CW = $clog2(2 * W);
  localparam int SW = $clog2(W);

  logic [W-1:0]   n_r, d_r, acc_r, sq_r, rem_r;
  logic [2*W-1:0] prod_r;
  logic [CW-1:0]  cnt_r;
  logic [SW-1:0]  s_r, r_r;
  mul_sel_t       sel_r;

  logic [W-1:0]   n_in, a_in, op_x, op_y, rem_new;
  logic [2*W-1:0] prod_w;
  logic [W:0]     rem_sh;
  logic           red_last;

  assign n_in = in_candidate[W-1:0];
  assign a_in = in_base[W-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MS_ACC_SQ:  begin op_x = acc_r; op_y = sq_r;  end
      MS_SQ_SQ:   begin op_x = sq_r;  op_y = sq_r;  end
      MS_ACC_ACC: begin op_x = acc_r; op_y = acc_r; end
      default:    begin op_x = acc_r; op_y = acc_r; end
    endcase
  end

  assign prod_w   = {{W{1'b0}}, op_x} * {{W{1'b0}}, op_y};
  assign rem_sh   = {rem_r, prod_r[2*W-1]};
  assign rem_new  = (rem_sh >= {1'b0, n_r}) ? W'(rem_sh - {1'b0, n_r}) : rem_sh[W-1:0];
  assign red_last = (cnt_r == CW'(2 * W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= n_in;
      d_r   <= n_in - W'(1);
      s_r   <= '0;
      r_r   <= '0;
      acc_r <= W'(1);
      sq_r  <= a_in;
    end
    if (cmd.strip) begin
      d_r <= d_r >> 1;
      s_r <= s_r + SW'(1);
    end
    if (cmd.mul_start) begin
      sel_r  <= cmd.mul_sel;
      prod_r <= prod_w;
      rem_r  <= '0;
      cnt_r  <= '0;
      unique case (cmd.mul_sel)
        MS_ACC_SQ:  d_r[0] <= 1'b0;
        MS_SQ_SQ:   d_r    <= d_r >> 1;
        MS_ACC_ACC: r_r    <= r_r + SW'(1);
        default:    ;
      endcase
    end
    if (cmd.red_step) begin
      prod_r <= prod_r << 1;
      rem_r  <= rem_new;
      cnt_r  <= cnt_r + CW'(1);
      if (red_last) begin
        if (sel_r == MS_SQ_SQ) sq_r <= rem_new;
        else acc_r <= rem_new;
      end
    end
  end

  assign sts.n_lt2      = ((n_in >> 1) == '0);
  assign sts.d_lsb      = d_r[0];
  assign sts.d_zero     = (d_r == '0);
  assign sts.acc_is1    = (acc_r == W'(1));
  assign sts.acc_is_nm1 = (acc_r == n_r - W'(1));
  assign sts.r_eq_s     = (r_r == s_r);
  assign sts.red_last   = red_last;

endmodule

// File: hdl/sprp_ctrl.sv
// ----------------------------------------------------------------------------
// sprp_ctrl: sequencing state machine and result register
// Steps through trailing-zero strip, exponentiation, squaring checks, output;
// a candidate below two goes straight to the bad-input result.
module sprp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_probable_prime,
  output logic           out_bad_input,
  input  sprp_pkg::sts_t sts,
  output sprp_pkg::cmd_t cmd
);
  import sprp_pkg::*;

  state_t state_r, state_nxt;
  logic   chk_r, out_valid_r, out_pp_r, out_bad_r;
  logic   out_free, out_load;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = sts.n_lt2 ? S_DONE_BAD : S_STRIP;
      S_STRIP: if (sts.d_lsb) state_nxt = S_EXP;
      S_EXP:   state_nxt = sts.d_zero ? S_CHK0 : S_RED;
      S_CHK0:  state_nxt = sts.acc_is1 ? S_DONE_T : S_CHK;
      S_CHK: begin
        priority if (sts.r_eq_s) state_nxt = S_DONE_F;
        else if (sts.acc_is_nm1) state_nxt = S_DONE_T;
        else state_nxt = S_RED;
      end
      S_RED:   if (sts.red_last) state_nxt = chk_r ? S_CHK : S_EXP;
      S_DONE_T, S_DONE_F, S_DONE_BAD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_STRIP: cmd.strip = !sts.d_lsb;
      S_EXP: begin
        cmd.mul_start = !sts.d_zero;
        cmd.mul_sel   = sts.d_lsb ? MS_ACC_SQ : MS_SQ_SQ;
      end
      S_CHK: begin
        cmd.mul_start = !sts.r_eq_s && !sts.acc_is_nm1;
        cmd.mul_sel   = MS_ACC_ACC;
      end
      S_RED:   cmd.red_step = 1'b1;
      S_DONE_T, S_DONE_F, S_DONE_BAD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) chk_r <= 1'b0;
      if (state_r == S_CHK0) chk_r <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pp_r  <= (state_r == S_DONE_T);
      out_bad_r <= (state_r == S_DONE_BAD);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_probable_prime = out_pp_r;
  assign out_bad_input      = out_bad_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted transfer did not start a test");
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result not presented");
  a_strip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STRIP) |-> !sts.d_zero)
    else $error("trailing-zero strip on zero value");
`endif

endmodule
